FILE: hw/rtl/wdt_pkg.sv
// ----------------------------------------------------------------------------
// wdt_pkg
// Shared types and codes for the watchdog/timer register block.
// ----------------------------------------------------------------------------
package wdt_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] REG_LOAD    = 3'd0;
  localparam logic [2:0] REG_COUNTER = 3'd1;
  localparam logic [2:0] REG_CONTROL = 3'd2;
  localparam logic [2:0] REG_IRQ_ST  = 3'd3;
  localparam logic [2:0] REG_RST_ST  = 3'd4;
  localparam logic [2:0] REG_DISABLE = 3'd5;

  localparam int CTL_ENABLE   = 0;
  localparam int CTL_RELOAD   = 1;
  localparam int CTL_IRQ_EN   = 2;
  localparam int CTL_WATCHDOG = 3;

  localparam logic [15:0] CTL_WR_MASK = 16'hFF0F;
  localparam logic [31:0] KEY_FIRST   = 32'h1234_5678;
  localparam logic [31:0] KEY_SECOND  = 32'h8765_4321;

  typedef struct packed {
    logic [31:0] write_data;
    logic [2:0]  reg_addr;
    logic [1:0]  func;
  } item_t;

  typedef struct packed {
    logic        reset_out;
    logic        irq;
    logic [31:0] read_data;
  } result_t;

endpackage

FILE: hw/rtl/wdt_core.sv
// ----------------------------------------------------------------------------
// wdt_core
// Register file, prescaler, down counter and disable-key logic. Applies one
// word per cycle when step is high and returns the result for that word.
// ----------------------------------------------------------------------------
module wdt_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  wdt_pkg::item_t   item,
  output wdt_pkg::result_t result
);

  logic [31:0] load_value;
  logic [31:0] load_value_next;
  logic [31:0] count_value;
  logic [31:0] count_value_next;
  logic [15:0] control_bits;
  logic [15:0] control_bits_next;
  logic [7:0]  prescale_count;
  logic [7:0]  prescale_count_next;
  logic        event_flag;
  logic        event_flag_next;
  logic        reset_flag;
  logic        reset_flag_next;
  logic        unlock_stage;
  logic        unlock_stage_next;
  logic [31:0] read_data;
  logic [31:0] count_dec;

  assign count_dec = count_value - 32'd1;

  always_comb begin
    load_value_next     = load_value;
    count_value_next    = count_value;
    control_bits_next   = control_bits;
    prescale_count_next = prescale_count;
    event_flag_next     = event_flag;
    reset_flag_next     = reset_flag;
    unlock_stage_next   = unlock_stage;
    read_data           = 32'd0;
    unique case (item.func)
      wdt_pkg::FUNC_READ: begin
        unique case (item.reg_addr)
          wdt_pkg::REG_LOAD:    read_data = load_value;
          wdt_pkg::REG_COUNTER: read_data = count_value;
          wdt_pkg::REG_CONTROL: read_data = {16'd0, control_bits};
          wdt_pkg::REG_IRQ_ST:  read_data = {31'd0, event_flag};
          wdt_pkg::REG_RST_ST:  read_data = {31'd0, reset_flag};
          default:              read_data = 32'd0;
        endcase
      end
      wdt_pkg::FUNC_WRITE: begin
        unique case (item.reg_addr)
          wdt_pkg::REG_LOAD: begin
            load_value_next  = item.write_data;
            count_value_next = item.write_data;
          end
          wdt_pkg::REG_COUNTER: count_value_next = item.write_data;
          wdt_pkg::REG_CONTROL: begin
            control_bits_next = (item.write_data[15:0] & wdt_pkg::CTL_WR_MASK);
            control_bits_next[wdt_pkg::CTL_WATCHDOG] =
              item.write_data[wdt_pkg::CTL_WATCHDOG] | control_bits[wdt_pkg::CTL_WATCHDOG];
          end
          wdt_pkg::REG_IRQ_ST: begin
            if (item.write_data[0]) event_flag_next = 1'b0;
          end
          wdt_pkg::REG_RST_ST: begin
            if (item.write_data[0]) reset_flag_next = 1'b0;
          end
          wdt_pkg::REG_DISABLE: begin
            if (item.write_data == wdt_pkg::KEY_FIRST) begin
              unlock_stage_next = 1'b1;
            end else if (item.write_data == wdt_pkg::KEY_SECOND && unlock_stage) begin
              control_bits_next[wdt_pkg::CTL_WATCHDOG] = 1'b0;
              unlock_stage_next = 1'b0;
            end else begin
              unlock_stage_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      wdt_pkg::FUNC_TICK: begin
        if (control_bits[wdt_pkg::CTL_ENABLE]) begin
          if (prescale_count >= control_bits[15:8]) begin
            prescale_count_next = 8'd0;
            if (count_value != 32'd0) begin
              count_value_next = count_dec;
              if (count_dec == 32'd0) begin
                if (control_bits[wdt_pkg::CTL_WATCHDOG]) begin
                  reset_flag_next = 1'b1;
                end else begin
                  event_flag_next = 1'b1;
                  if (control_bits[wdt_pkg::CTL_RELOAD]) count_value_next = load_value;
                end
              end
            end
          end else begin
            prescale_count_next = prescale_count + 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign result.read_data = read_data;
  assign result.irq       = event_flag_next & control_bits_next[wdt_pkg::CTL_IRQ_EN]
                            & ~control_bits_next[wdt_pkg::CTL_WATCHDOG];
  assign result.reset_out = reset_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_value     <= 32'd0;
      count_value    <= 32'd0;
      control_bits   <= 16'd0;
      prescale_count <= 8'd0;
      event_flag     <= 1'b0;
      reset_flag     <= 1'b0;
      unlock_stage   <= 1'b0;
    end else if (step) begin
      load_value     <= load_value_next;
      count_value    <= count_value_next;
      control_bits   <= control_bits_next;
      prescale_count <= prescale_count_next;
      event_flag     <= event_flag_next;
      reset_flag     <= reset_flag_next;
      unlock_stage   <= unlock_stage_next;
    end
  end

  a_wd_exit_by_keys: assert property (@(posedge clk) disable iff (rst)
    $fell(control_bits[wdt_pkg::CTL_WATCHDOG]) |->
      $past(rst) || $past(step && item.func == wdt_pkg::FUNC_WRITE
        && item.reg_addr == wdt_pkg::REG_DISABLE
        && item.write_data == wdt_pkg::KEY_SECOND && unlock_stage))
    else $error("watchdog mode left without key sequence");

  a_count_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(count_value))
    else $error("counter moved without a word");

  a_reset_flag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(reset_flag) |->
      $past(step && item.func == wdt_pkg::FUNC_TICK && control_bits[wdt_pkg::CTL_WATCHDOG]))
    else $error("reset flag set outside a watchdog tick");

  a_unlock_only_disable: assert property (@(posedge clk) disable iff (rst)
    !(step && item.func == wdt_pkg::FUNC_WRITE && item.reg_addr == wdt_pkg::REG_DISABLE)
      |=> $stable(unlock_stage))
    else $error("unlock stage changed without a disable write");

endmodule

FILE: hw/rtl/watchdog_timer_registers_top.sv
// ----------------------------------------------------------------------------
// watchdog_timer_registers_top
// Private watchdog/timer register block with stream input and output.
//
// Each input word on s_* is a bus read, a bus write, a timer tick or (func
// 3) no operation, selected by s_tuser. Every input word produces exactly
// one output word on m_* carrying the read data and the irq and reset_out
// levels after the word has been applied.
//
// Path: an accepted input word sits in the input register, moves to the
// result register once that register is empty or being taken, and shows
// on m_tvalid from then on.
// Throughput: one word per cycle while m_tready is high, set by the
// single-pass update of the register file between the input and result
// registers. Stall: while m_tready is low the result register holds; the
// input register still takes one more word if it is empty, then s_tready
// drops until the result is taken. No word is lost or repeated.
// Reset: rst clears all timer state and both pipeline valids and holds
// s_tready low; the block accepts words on the first cycle after reset.
// ----------------------------------------------------------------------------
module watchdog_timer_registers_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // write_data
  input  logic [4:0]  s_tuser,   // func[1:0], reg_addr[4:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_data
  output logic [1:0]  m_tuser    // irq[0], reset_out[1]
);

  wdt_pkg::item_t   in_item;
  logic             in_valid;
  logic             advance;
  logic             step;
  wdt_pkg::result_t core_result;
  wdt_pkg::result_t out_result;
  logic             out_valid;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.write_data <= s_tdata;
      in_item.reg_addr   <= s_tuser[4:2];
      in_item.func       <= s_tuser[1:0];
    end
  end

  wdt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_result.read_data;
  assign m_tuser  = {out_result.reset_out, out_result.irq};

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the watchdog/timer register block. A short table of
// directed words covers reset values, register extremes, the sticky watchdog
// bit and the disable keys. Random reads, writes and ticks follow. A local
// timer model predicts each output word that the table leaves open, and the
// test checks each output word in order while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [2:0] REG_UNUSED_LO = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;
  localparam int         N_RANDOM      = 1500;

  typedef struct {
    wdt_pkg::item_t   word;
    bit               fixed;
    wdt_pkg::result_t want;
  } row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // write_data
  logic [4:0]  s_tuser  = '0;   // func[1:0], reg_addr[4:2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // read_data
  logic [1:0]  m_tuser;         // irq[0], reset_out[1]

  logic [31:0] tm_load     = '0;
  logic [31:0] tm_count    = '0;
  logic [15:0] tm_ctrl     = '0;
  logic [7:0]  tm_presc    = '0;
  logic        tm_event    = 1'b0;
  logic        tm_rst_flag = 1'b0;
  logic        tm_armed    = 1'b0;

  wdt_pkg::result_t due_outputs[$];
  row_t             rows[$];
  int               errors   = 0;
  int               rx_wait  = 0;
  int               rx_count = 0;
  bit               rx_burst = 1'b0;
  bit               tx_burst = 1'b0;

  watchdog_timer_registers_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic wdt_pkg::result_t next_timer_output(wdt_pkg::item_t w);
    wdt_pkg::result_t r;
    logic             wd;
    r = '0;
    case (w.func)
      wdt_pkg::FUNC_READ: begin
        case (w.reg_addr)
          wdt_pkg::REG_LOAD:    r.read_data = tm_load;
          wdt_pkg::REG_COUNTER: r.read_data = tm_count;
          wdt_pkg::REG_CONTROL: r.read_data = {16'h0, tm_ctrl};
          wdt_pkg::REG_IRQ_ST:  r.read_data = {31'h0, tm_event};
          wdt_pkg::REG_RST_ST:  r.read_data = {31'h0, tm_rst_flag};
          default:              r.read_data = '0;
        endcase
      end
      wdt_pkg::FUNC_WRITE: begin
        case (w.reg_addr)
          wdt_pkg::REG_LOAD: begin
            tm_load  = w.write_data;
            tm_count = w.write_data;
          end
          wdt_pkg::REG_COUNTER: tm_count = w.write_data;
          wdt_pkg::REG_CONTROL: begin
            wd = tm_ctrl[wdt_pkg::CTL_WATCHDOG];
            tm_ctrl = w.write_data[15:0] & wdt_pkg::CTL_WR_MASK;
            tm_ctrl[wdt_pkg::CTL_WATCHDOG] = tm_ctrl[wdt_pkg::CTL_WATCHDOG] | wd;
          end
          wdt_pkg::REG_IRQ_ST: if (w.write_data[0]) tm_event = 1'b0;
          wdt_pkg::REG_RST_ST: if (w.write_data[0]) tm_rst_flag = 1'b0;
          wdt_pkg::REG_DISABLE: begin
            if (w.write_data == wdt_pkg::KEY_FIRST) begin
              tm_armed = 1'b1;
            end else if (w.write_data == wdt_pkg::KEY_SECOND && tm_armed) begin
              tm_ctrl[wdt_pkg::CTL_WATCHDOG] = 1'b0;
              tm_armed = 1'b0;
            end else begin
              tm_armed = 1'b0;
            end
          end
          default: ;
        endcase
      end
      wdt_pkg::FUNC_TICK: begin
        if (tm_ctrl[wdt_pkg::CTL_ENABLE]) begin
          if (tm_presc >= tm_ctrl[15:8]) begin
            tm_presc = '0;
            if (tm_count != 32'd0) begin
              tm_count = tm_count - 32'd1;
              if (tm_count == 32'd0) begin
                if (tm_ctrl[wdt_pkg::CTL_WATCHDOG]) begin
                  tm_rst_flag = 1'b1;
                end else begin
                  tm_event = 1'b1;
                  if (tm_ctrl[wdt_pkg::CTL_RELOAD]) tm_count = tm_load;
                end
              end
            end
          end else begin
            tm_presc = tm_presc + 8'd1;
          end
        end
      end
      default: ;
    endcase
    r.irq       = tm_event && tm_ctrl[wdt_pkg::CTL_IRQ_EN] && !tm_ctrl[wdt_pkg::CTL_WATCHDOG];
    r.reset_out = tm_rst_flag;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [2:0] a, logic [31:0] d,
                                  bit fx = 1'b0, logic [31:0] rd = '0,
                                  logic irq = 1'b0, logic ro = 1'b0);
    row_t row;
    row.word.func       = f;
    row.word.reg_addr   = a;
    row.word.write_data = d;
    row.fixed           = fx;
    row.want.read_data  = rd;
    row.want.irq        = irq;
    row.want.reset_out  = ro;
    rows.push_back(row);
  endfunction

  function automatic wdt_pkg::item_t random_word();
    wdt_pkg::item_t w;
    int             pick;
    pick         = $urandom_range(0, 99);
    w.func       = wdt_pkg::FUNC_WRITE;
    w.reg_addr   = 3'($urandom_range(0, 7));
    w.write_data = $urandom;
    if (pick < 45) begin
      w.func = wdt_pkg::FUNC_TICK;
    end else if (pick < 60) begin
      w.func = wdt_pkg::FUNC_READ;
    end else if (pick < 70) begin
      w.reg_addr = $urandom_range(0, 1) ? wdt_pkg::REG_LOAD : wdt_pkg::REG_COUNTER;
      if ($urandom_range(0, 7) != 0) w.write_data = $urandom_range(0, 12);
    end else if (pick < 80) begin
      w.reg_addr = wdt_pkg::REG_CONTROL;
      if ($urandom_range(0, 7) != 0) begin
        w.write_data[15:8] = 8'($urandom_range(0, 3));
        w.write_data[wdt_pkg::CTL_ENABLE] = ($urandom_range(0, 4) != 0);
        w.write_data[wdt_pkg::CTL_WATCHDOG] = ($urandom_range(0, 9) == 0);
      end
    end else if (pick < 87) begin
      w.reg_addr = $urandom_range(0, 1) ? wdt_pkg::REG_IRQ_ST : wdt_pkg::REG_RST_ST;
    end else if (pick < 95) begin
      w.reg_addr = wdt_pkg::REG_DISABLE;
      case ($urandom_range(0, 4))
        0, 1:    w.write_data = wdt_pkg::KEY_FIRST;
        2, 3:    w.write_data = wdt_pkg::KEY_SECOND;
        default: ;
      endcase
    end else if (pick < 97) begin
      w.func = FUNC_UNUSED;
    end else begin
      w.reg_addr = $urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI;
    end
    return w;
  endfunction

  task automatic send_word(wdt_pkg::item_t w, bit fixed, wdt_pkg::result_t want, int gap);
    wdt_pkg::result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= w.write_data;
    s_tuser  <= {w.reg_addr, w.func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = next_timer_output(w);
    due_outputs.push_back(fixed ? want : r);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    wdt_pkg::result_t exp_out;
    if (!rst && m_tvalid && m_tready) begin
      if (due_outputs.size() == 0) begin
        $error("unexpected output word: read_data %h irq %b reset_out %b",
               m_tdata, m_tuser[0], m_tuser[1]);
        errors++;
      end else begin
        exp_out = due_outputs.pop_front();
        if (m_tdata !== exp_out.read_data) begin
          $error("read_data mismatch: expected %h, got %h", exp_out.read_data, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== exp_out.irq) begin
          $error("irq mismatch: expected %b, got %b", exp_out.irq, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== exp_out.reset_out) begin
          $error("reset_out mismatch: expected %b, got %b", exp_out.reset_out, m_tuser[1]);
          errors++;
        end
      end
      rx_count++;
      if (rx_count % 100 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 19);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    m_tready <= !rst && (rx_wait == 0);
  end

  initial begin
    int             drain;
    wdt_pkg::item_t w;
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_LOAD,    32'h0, 1'b1, 32'h0);
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_CONTROL, 32'h0, 1'b1, 32'h0);
    add_row(wdt_pkg::FUNC_READ,  REG_UNUSED_LO,        32'h0, 1'b1, 32'h0);
    add_row(FUNC_UNUSED,         wdt_pkg::REG_LOAD,    32'hFFFF_FFFF, 1'b1, 32'h0);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_LOAD,    32'h3);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_CONTROL, 32'h0000_0007);
    add_row(wdt_pkg::FUNC_TICK,  wdt_pkg::REG_LOAD,    32'h0);
    add_row(wdt_pkg::FUNC_TICK,  wdt_pkg::REG_LOAD,    32'h0);
    add_row(wdt_pkg::FUNC_TICK,  wdt_pkg::REG_LOAD,    32'h0);
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_IRQ_ST,  32'h0);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_IRQ_ST,  32'hFFFF_FFFE);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_IRQ_ST,  32'h1);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_LOAD,    32'hFFFF_FFFF);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_CONTROL, 32'hFFFF_FFFF);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_CONTROL, 32'h0);
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_CONTROL, 32'h0);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_DISABLE, wdt_pkg::KEY_SECOND);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_DISABLE, wdt_pkg::KEY_FIRST);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_DISABLE, wdt_pkg::KEY_SECOND);
    add_row(wdt_pkg::FUNC_WRITE, REG_UNUSED_HI,        32'hFFFF_FFFF);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_COUNTER, 32'h1);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_CONTROL, 32'h0000_0009);
    add_row(wdt_pkg::FUNC_TICK,  wdt_pkg::REG_LOAD,    32'h0);
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_RST_ST,  32'h0);
    add_row(wdt_pkg::FUNC_WRITE, wdt_pkg::REG_RST_ST,  32'h1);
    add_row(wdt_pkg::FUNC_READ,  wdt_pkg::REG_DISABLE, 32'h0, 1'b1, 32'h0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_word(rows[i].word, rows[i].fixed, rows[i].want, $urandom_range(0, 19));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (n == N_RANDOM / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (due_outputs.size() != 0) @(posedge clk);
      end
      w = random_word();
      send_word(w, 1'b0, '0, tx_burst ? 0 : $urandom_range(0, 19));
    end
    s_tvalid <= 1'b0;

    drain = 0;
    while (due_outputs.size() != 0 && drain < 10000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (due_outputs.size() != 0) begin
      $error("%0d expected output words never arrived", due_outputs.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wdt_pkg.sv
hw/rtl/wdt_core.sv
hw/rtl/watchdog_timer_registers_top.sv
test/tb.sv
